// ===== hdl/rdsd_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants of the digital rheostat SPI device.
package rdsd_pkg;

   localparam int MEM_SLOTS     = 20;
   localparam int WIPER_BITS    = 10;
   localparam int CMD_W         = 6;
   localparam int DATA_W        = 10;
   localparam int ANS_W         = 11;
   localparam int CTRL_W        = 4;
   localparam int CTRL_WR_BITS  = 3;
   localparam int SLOT_IDX_W    = (MEM_SLOTS > 1) ? $clog2(MEM_SLOTS) : 1;
   localparam int SLOT_CNT_W    = $clog2(MEM_SLOTS + 1);
   localparam int MAP_LOW_ADDR  = 20;
   localparam int MAP_HIGH_ADDR = 21;
   localparam int MAP_SLICE     = 11;
   localparam int MAP_BITS      = 2 * MAP_SLICE;

   localparam int CTRL_PROG_BIT    = 0;
   localparam int CTRL_WREN_BIT    = 1;
   localparam int CTRL_SUCCESS_BIT = 3;

   localparam logic [WIPER_BITS-1:0] MIDSCALE = WIPER_BITS'(1) << (WIPER_BITS - 1);

   typedef enum logic [CMD_W-1:0] {
      CMD_NOP      = 6'd0,
      CMD_WRWIPER  = 6'd1,
      CMD_RDWIPER  = 6'd2,
      CMD_STORE    = 6'd3,
      CMD_RESET    = 6'd4,
      CMD_RDMEM    = 6'd5,
      CMD_WRCTRL   = 6'd6,
      CMD_RDCTRL   = 6'd7,
      CMD_SHUTDOWN = 6'd8,
      CMD_HIZ      = 6'd32
   } cmd_type;

   typedef struct packed {
      logic [DATA_W-1:0] data;
      logic [CMD_W-1:0]  command;
   } frame_type;

   typedef struct packed {
      logic              open_circuit;
      logic [DATA_W-1:0] wiper_now;
      logic              sdo_driven;
      logic [ANS_W-1:0]  read_data;
   } result_type;

endpackage

// ===== hdl/rdsd_in_reg.sv =====
`timescale 1ns / 1ps
// Input register: holds one accepted frame until the execute stage takes it.
module rdsd_in_reg
   import rdsd_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      in_valid,
   output logic      in_ready,
   input  frame_type in_frame,
   input  logic      take,
   output logic      fire,
   output frame_type frame
);

   logic      valid_ff;
   frame_type frame_ff;

   assign in_ready = !valid_ff || take;
   assign fire     = valid_ff && take;
   assign frame    = frame_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         frame_ff <= in_frame;
      end
   end

endmodule

// ===== hdl/rdsd_exec.sv =====
`timescale 1ns / 1ps
// Command decode, device state and result formation for one frame.
module rdsd_exec
   import rdsd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       fire,
   input  frame_type  frame,
   output result_type result
);

   logic [WIPER_BITS-1:0] wiper_ff, wiper_in;
   logic [WIPER_BITS-1:0] last_ff, last_in;
   logic [CTRL_W-1:0]     ctrl_ff, ctrl_in;
   logic [SLOT_CNT_W-1:0] slots_ff, slots_in;
   logic                  shut_ff, shut_in;
   logic                  hiz_ff, hiz_in;
   logic [ANS_W-1:0]      pend_ff, pend_in;
   logic [DATA_W-1:0]     mem [MEM_SLOTS];

   cmd_type               op;
   logic                  store_en;
   logic [MAP_BITS-1:0]   used_map;
   logic [ANS_W-1:0]      mem_answer;

   assign op = cmd_type'(frame.command);

   always_comb begin
      for (int i = 0; i < MAP_BITS; i++) begin
         used_map[i] = (i < int'(slots_ff));
      end
   end

   always_comb begin
      if (frame.data == DATA_W'(MAP_LOW_ADDR)) begin
         mem_answer = used_map[MAP_SLICE-1:0];
      end else if (frame.data == DATA_W'(MAP_HIGH_ADDR)) begin
         mem_answer = used_map[MAP_BITS-1:MAP_SLICE];
      end else if (frame.data < DATA_W'(MEM_SLOTS) && frame.data < DATA_W'(slots_ff)) begin
         mem_answer = ANS_W'(mem[frame.data[SLOT_IDX_W-1:0]]);
      end else begin
         mem_answer = '0;
      end
   end

   always_comb begin
      wiper_in = wiper_ff;
      last_in  = last_ff;
      ctrl_in  = ctrl_ff;
      slots_in = slots_ff;
      shut_in  = shut_ff;
      pend_in  = '0;
      store_en = 1'b0;
      case (op)
         CMD_WRWIPER: begin
            if (ctrl_ff[CTRL_WREN_BIT]) begin
               wiper_in = frame.data[WIPER_BITS-1:0];
            end
         end
         CMD_RDWIPER: begin
            pend_in = ANS_W'(wiper_ff);
         end
         CMD_STORE: begin
            if (ctrl_ff[CTRL_PROG_BIT] && slots_ff < SLOT_CNT_W'(MEM_SLOTS)) begin
               store_en                  = 1'b1;
               last_in                   = wiper_ff;
               slots_in                  = slots_ff + SLOT_CNT_W'(1);
               ctrl_in[CTRL_SUCCESS_BIT] = 1'b1;
            end
         end
         CMD_RESET: begin
            wiper_in = (slots_ff != '0) ? last_ff : MIDSCALE;
         end
         CMD_RDMEM: begin
            pend_in = mem_answer;
         end
         CMD_WRCTRL: begin
            ctrl_in[CTRL_WR_BITS-1:0] = frame.data[CTRL_WR_BITS-1:0];
         end
         CMD_RDCTRL: begin
            pend_in = ANS_W'(ctrl_ff);
         end
         CMD_SHUTDOWN: begin
            shut_in = frame.data[0];
         end
         default: begin
         end
      endcase
      hiz_in = (op == CMD_HIZ);
   end

   assign result.read_data    = hiz_ff ? '0 : pend_ff;
   assign result.sdo_driven   = !hiz_ff;
   assign result.wiper_now    = DATA_W'(wiper_in);
   assign result.open_circuit = shut_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         wiper_ff <= MIDSCALE;
         last_ff  <= MIDSCALE;
         ctrl_ff  <= '0;
         slots_ff <= '0;
         shut_ff  <= 1'b0;
         hiz_ff   <= 1'b0;
         pend_ff  <= '0;
      end else if (fire) begin
         wiper_ff <= wiper_in;
         last_ff  <= last_in;
         ctrl_ff  <= ctrl_in;
         slots_ff <= slots_in;
         shut_ff  <= shut_in;
         hiz_ff   <= hiz_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire && store_en) begin
         mem[slots_ff[SLOT_IDX_W-1:0]] <= DATA_W'(wiper_ff);
      end
   end

   a_slots_bound: assert property (@(posedge clock) disable iff (reset)
      slots_ff <= SLOT_CNT_W'(MEM_SLOTS))
      else $error("slot count beyond memory size");

   a_slots_step: assert property (@(posedge clock) disable iff (reset)
      !fire |=> $stable(slots_ff))
      else $error("slot count moved without an item");

   a_store_success: assert property (@(posedge clock) disable iff (reset)
      (fire && store_en) |=> ctrl_ff[CTRL_SUCCESS_BIT] && last_ff == $past(wiper_ff))
      else $error("store did not set success or latch wiper");

   a_hiz_follow: assert property (@(posedge clock) disable iff (reset)
      fire |=> hiz_ff == ($past(frame.command) == CMD_HIZ))
      else $error("output enable does not follow last command");

endmodule

// ===== hdl/rdsd_out_reg.sv =====
`timescale 1ns / 1ps
// Result register: holds one result item until the consumer takes it.
module rdsd_out_reg
   import rdsd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       fire,
   input  result_type result,
   output logic       take,
   output logic       out_valid,
   input  logic       out_ready,
   output result_type out_result
);

   logic       valid_ff;
   result_type result_ff;

   assign take       = !valid_ff || out_ready;
   assign out_valid  = valid_ff;
   assign out_result = result_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (take) begin
         valid_ff <= fire;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         result_ff <= result;
      end
   end

endmodule

// ===== hdl/digital_rheostat_spi_device.sv =====
// A frame accepted into the input register is executed and loaded into the result register
// once the result register can take it; its result item is then offered on the rsp port.
// Throughput: one frame per cycle, set by the single execute stage between the
// input register and the result register; backpressure stalls both registers.
// Reset: synchronous, active high; the wiper returns to midscale, control,
// slot count, shutdown, SDO release and pending answer clear, no clearing pass.
`timescale 1ns / 1ps
module digital_rheostat_spi_device
   import rdsd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // command[5:0], data[15:6]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata    // read_data[10:0], sdo_driven[11], wiper_now[21:12],
                                    // open_circuit[22], zero[23]
);

   logic       fire;
   logic       take;
   frame_type  frame;
   result_type result;
   result_type out_result;

   rdsd_in_reg u_in_reg (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_tvalid),
      .in_ready (req_tready),
      .in_frame (frame_type'(req_tdata)),
      .take     (take),
      .fire     (fire),
      .frame    (frame)
   );

   rdsd_exec u_exec (
      .clock  (clock),
      .reset  (reset),
      .fire   (fire),
      .frame  (frame),
      .result (result)
   );

   rdsd_out_reg u_out_reg (
      .clock      (clock),
      .reset      (reset),
      .fire       (fire),
      .result     (result),
      .take       (take),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_result (out_result)
   );

   assign rsp_tdata = {1'b0, out_result};

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the digital rheostat SPI device: frames checked against a predictor.
module tb;
   import rdsd_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int PRINT_CAP      = 25;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata  = '0;  // command[5:0], data[15:6]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;        // read_data[10:0], sdo_driven[11], wiper_now[21:12],
                                  // open_circuit[22], zero[23]

   logic [WIPER_BITS-1:0] ohm_wiper      = MIDSCALE;
   logic [CTRL_W-1:0]     ctl            = '0;
   logic [DATA_W-1:0]     otp_mem [MEM_SLOTS] = '{default: '0};
   int                    otp_used       = 0;
   logic                  sd_flag        = 1'b0;
   logic                  sdo_released   = 1'b0;
   logic [ANS_W-1:0]      latched_answer = '0;

   result_type frame_outcomes [$];
   result_type seen_word, due_word;

   int mismatches     = 0;
   int frames_sent    = 0;
   int results_seen   = 0;
   int stores_done    = 0;
   int stores_refused = 0;
   int idle_cycles    = 0;
   int stall_left     = 0;
   int gap_odds       = 20;

   digital_rheostat_spi_device DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #10 clock = ~clock;

   function automatic result_type apply_frame(input logic [CMD_W-1:0] cmd,
                                              input logic [DATA_W-1:0] d);
      result_type          r;
      logic [ANS_W-1:0]    answer;
      logic [MAP_BITS-1:0] used_map;
      r.sdo_driven = !sdo_released;
      r.read_data  = sdo_released ? '0 : latched_answer;
      answer       = '0;
      used_map     = (MAP_BITS'(1) << otp_used) - MAP_BITS'(1);
      case (cmd)
         CMD_WRWIPER: if (ctl[CTRL_WREN_BIT]) ohm_wiper = d[WIPER_BITS-1:0];
         CMD_RDWIPER: answer = ANS_W'(ohm_wiper);
         CMD_STORE: begin
            if (ctl[CTRL_PROG_BIT] && otp_used < MEM_SLOTS) begin
               otp_mem[SLOT_IDX_W'(otp_used)] = DATA_W'(ohm_wiper);
               otp_used++;
               ctl[CTRL_SUCCESS_BIT] = 1'b1;
               stores_done++;
            end else begin
               stores_refused++;
            end
         end
         CMD_RESET: begin
            if (otp_used > 0) ohm_wiper = otp_mem[SLOT_IDX_W'(otp_used - 1)][WIPER_BITS-1:0];
            else ohm_wiper = MIDSCALE;
         end
         CMD_RDMEM: begin
            if (d == MAP_LOW_ADDR) answer = used_map[MAP_SLICE-1:0];
            else if (d == MAP_HIGH_ADDR) answer = used_map[MAP_BITS-1:MAP_SLICE];
            else if (d < MEM_SLOTS) answer = ANS_W'(otp_mem[d[SLOT_IDX_W-1:0]]);
         end
         CMD_WRCTRL:   ctl = {ctl[CTRL_SUCCESS_BIT], d[CTRL_WR_BITS-1:0]};
         CMD_RDCTRL:   answer = ANS_W'(ctl);
         CMD_SHUTDOWN: sd_flag = d[0];
         default: ;
      endcase
      sdo_released   = (cmd == CMD_HIZ);
      latched_answer = answer;
      r.wiper_now    = DATA_W'(ohm_wiper);
      r.open_circuit = sd_flag;
      return r;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      mismatches++;
      if (mismatches <= PRINT_CAP)
         $display("%0t ns: mismatch on %s: got %0d, want %0d", $time, what, got, want);
   endtask

   // Call at a falling edge; returns at the falling edge after the item is taken.
   task automatic send_frame(input logic [CMD_W-1:0] cmd, input logic [DATA_W-1:0] d);
      frame_type f;
      int        gap;
      if (gap_odds != 0 && $urandom_range(0, 99) < gap_odds) begin
         gap = $urandom_range(1, 6);
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      f.command = cmd;
      f.data    = d;
      req_tdata  <= f;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      frame_outcomes.push_back(apply_frame(cmd, d));
      frames_sent++;
      @(negedge clock);
   endtask

   task automatic wait_for_results();
      req_tvalid <= 1'b0;
      while (frame_outcomes.size() != 0) @(negedge clock);
   endtask

   task automatic pick_random_frame(output logic [CMD_W-1:0] cmd,
                                    output logic [DATA_W-1:0] d);
      int roll;
      roll = $urandom_range(0, 99);
      d    = DATA_W'($urandom);
      if (roll < 15) cmd = CMD_WRWIPER;
      else if (roll < 25) cmd = CMD_RDWIPER;
      else if (roll < 28) cmd = CMD_STORE;
      else if (roll < 34) cmd = CMD_RESET;
      else if (roll < 48) begin
         cmd = CMD_RDMEM;
         if ($urandom_range(0, 4) != 0) d = DATA_W'($urandom_range(0, MAP_HIGH_ADDR));
      end else if (roll < 58) begin
         cmd = CMD_WRCTRL;
         if ($urandom_range(0, 4) != 0) d[CTRL_WREN_BIT] = 1'b1;
      end else if (roll < 68) cmd = CMD_RDCTRL;
      else if (roll < 76) cmd = CMD_SHUTDOWN;
      else if (roll < 84) cmd = CMD_HIZ;
      else if (roll < 94) cmd = CMD_NOP;
      else begin
         cmd = CMD_W'($urandom_range(9, 62));
         if (cmd >= CMD_HIZ) cmd = cmd + 1'b1;
      end
   endtask

   task automatic test_power_up();
      send_frame(CMD_RDWIPER, '0);
      send_frame(CMD_RDCTRL, '0);
      send_frame(CMD_RDMEM, DATA_W'(MAP_LOW_ADDR));
      send_frame(CMD_RESET, '0);
   endtask

   task automatic test_wiper_lock();
      send_frame(CMD_WRWIPER, 10'h3FF);
      send_frame(CMD_WRCTRL, 10'h002);
      send_frame(CMD_WRWIPER, 10'h000);
      send_frame(CMD_WRWIPER, 10'h3FF);
   endtask

   task automatic test_otp_store();
      send_frame(CMD_WRCTRL, 10'h000);
      send_frame(CMD_STORE, 10'h3FF);
      send_frame(CMD_WRCTRL, 10'h3FF);
      send_frame(CMD_STORE, 10'h000);
      send_frame(CMD_RDMEM, 10'h000);
      send_frame(CMD_RDMEM, 10'h3FF);
      send_frame(CMD_RESET, 10'h3FF);
   endtask

   task automatic test_control_shutdown();
      send_frame(CMD_RDCTRL, '0);
      send_frame(CMD_SHUTDOWN, 10'h001);
      send_frame(CMD_SHUTDOWN, 10'h3FE);
   endtask

   task automatic test_hiz_unknown();
      send_frame(CMD_RDWIPER, '0);
      send_frame(CMD_HIZ, 10'h3FF);
      send_frame(CMD_HIZ, 10'h000);
      send_frame(CMD_NOP, '0);
      send_frame(6'h3F, 10'h3FF);
      send_frame(6'h21, 10'h155);
   endtask

   task automatic test_random_traffic(input int blocks, input int per_block,
                                      input bit keep_odds);
      logic [CMD_W-1:0]  cmd;
      logic [DATA_W-1:0] d;
      int                levels [4] = '{0, 10, 25, 50};
      for (int b = 0; b < blocks; b++) begin
         if (!keep_odds) gap_odds = levels[$urandom_range(0, 3)];
         for (int i = 0; i < per_block; i++) begin
            pick_random_frame(cmd, d);
            send_frame(cmd, d);
         end
         if (b == blocks / 2) wait_for_results();
      end
   endtask

   task automatic test_memory_exhaust();
      gap_odds = 20;
      send_frame(CMD_WRCTRL, 10'h003);
      while (otp_used < MEM_SLOTS) begin
         send_frame(CMD_WRWIPER, DATA_W'($urandom));
         send_frame(CMD_STORE, DATA_W'($urandom));
      end
      send_frame(CMD_STORE, 10'h3FF);
      send_frame(CMD_RDCTRL, '0);
      send_frame(CMD_RDMEM, DATA_W'(MAP_LOW_ADDR));
      send_frame(CMD_RDMEM, DATA_W'(MAP_HIGH_ADDR));
      for (int a = 0; a < MEM_SLOTS; a++) send_frame(CMD_RDMEM, DATA_W'(a));
      send_frame(CMD_RDMEM, DATA_W'(MAP_HIGH_ADDR + 1));
      send_frame(CMD_RESET, '0);
      send_frame(CMD_RDWIPER, '0);
   endtask

   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left--;
      end else if (gap_odds != 0 && $urandom_range(0, 99) < gap_odds) begin
         stall_left = $urandom_range(1, 6) - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen_word = rsp_tdata[$bits(result_type)-1:0];
         results_seen++;
         if (frame_outcomes.size() == 0) begin
            report_mismatch("unexpected result", 0, 0);
         end else begin
            due_word = frame_outcomes.pop_front();
            if (seen_word.read_data !== due_word.read_data)
               report_mismatch("read_data", int'(seen_word.read_data),
                               int'(due_word.read_data));
            if (seen_word.sdo_driven !== due_word.sdo_driven)
               report_mismatch("sdo_driven", int'(seen_word.sdo_driven),
                               int'(due_word.sdo_driven));
            if (seen_word.wiper_now !== due_word.wiper_now)
               report_mismatch("wiper_now", int'(seen_word.wiper_now),
                               int'(due_word.wiper_now));
            if (seen_word.open_circuit !== due_word.open_circuit)
               report_mismatch("open_circuit", int'(seen_word.open_circuit),
                               int'(due_word.open_circuit));
         end
      end
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Timeout: no item moved for %0d cycles", WATCHDOG_LIMIT);
         $display("Verification failed");
         $finish;
      end
   end

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_power_up();
      test_wiper_lock();
      test_otp_store();
      test_control_shutdown();
      test_hiz_unknown();
      wait_for_results();
      test_random_traffic(26, 50, 1'b0);
      test_memory_exhaust();
      gap_odds = 0;
      test_random_traffic(1, 80, 1'b1);
      wait_for_results();
      repeat (4) @(negedge clock);
      if (frame_outcomes.size() != 0)
         report_mismatch("results left over", frame_outcomes.size(), 0);
      $display("Run: %0d frames sent, %0d results checked, %0d mismatches", frames_sent,
               results_seen, mismatches);
      $display("Memory: %0d stores taken, %0d refused, %0d of %0d slots used", stores_done,
               stores_refused, otp_used, MEM_SLOTS);
      if (mismatches == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

// ===== filelist.f =====
hdl/rdsd_pkg.sv
hdl/rdsd_in_reg.sv
hdl/rdsd_exec.sv
hdl/rdsd_out_reg.sv
hdl/digital_rheostat_spi_device.sv
tb/tb.sv
